@@ rtl/core/gprsc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gprsc_pkg;

  // Field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned BTN_W      = 21;
  localparam int unsigned AXIS_W     = 12;
  localparam int unsigned DZ_W       = 11;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned NUM_AXES   = 4;
  localparam int unsigned AXIS_IDX_W = 2;

  // Byte capture
  localparam int unsigned STORE_BYTES = 16;
  localparam int unsigned LEN_W       = 5;
  localparam logic [LEN_W-1:0] FULL_MIN_LEN  = 5'd16;
  localparam logic [LEN_W-1:0] SHORT_MIN_LEN = 5'd11;

  // Axis conditioning
  localparam logic [AXIS_W-1:0] AXIS_MID = 12'd2048;
  localparam logic [AXIS_W-1:0] AXIS_MAX = 12'd4095;
  localparam logic [DZ_W-1:0]   DZ_RESET = 11'd48;

  localparam int unsigned CALIB_SAMPLES_DEF = 20;

  // Report kind and format codes
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SHORT   = 2'd2;
  localparam logic [KIND_W-1:0] FMT_NONE     = 2'd0;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_DIV  = 5'b00100,
    S_COND = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic                  in_accept;
    logic                  eval;
    logic                  div;
    logic                  calib_set;
    logic                  cond;
    logic                  emit;
    logic [AXIS_IDX_W-1:0] axis;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic ok;
    logic calib_hit;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/core/gprsc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Report byte channel
interface gprsc_byte_if;
  logic                              valid;
  logic                              ready;
  logic [gprsc_pkg::BYTE_W-1:0]      data_byte;
  logic [gprsc_pkg::KIND_W-1:0]      report_kind;
  logic                              last_byte;

  modport source (output valid, data_byte, report_kind, last_byte, input ready);
  modport sink   (input valid, data_byte, report_kind, last_byte, output ready);
endinterface

// Snapshot result channel
interface gprsc_snap_if;
  logic                              valid;
  logic                              ready;
  logic                              parsed_ok;
  logic [gprsc_pkg::KIND_W-1:0]      format_used;
  logic [gprsc_pkg::BTN_W-1:0]       buttons;
  logic [gprsc_pkg::AXIS_W-1:0]      left_x;
  logic [gprsc_pkg::AXIS_W-1:0]      left_y;
  logic [gprsc_pkg::AXIS_W-1:0]      right_x;
  logic [gprsc_pkg::AXIS_W-1:0]      right_y;
  logic [gprsc_pkg::COUNT_W-1:0]     update_count;
  logic [gprsc_pkg::COUNT_W-1:0]     error_count;

  modport source (output valid, parsed_ok, format_used, buttons, left_x, left_y, right_x,
                  right_y, update_count, error_count, input ready);
  modport sink   (input valid, parsed_ok, format_used, buttons, left_x, left_y, right_x,
                  right_y, update_count, error_count, output ready);
endinterface

// Deadzone write channel
interface gprsc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [gprsc_pkg::DZ_W-1:0]        deadzone;

  modport source (output valid, deadzone, input ready);
  modport sink   (input valid, deadzone, output ready);
endinterface

`default_nettype wire

@@ rtl/core/gprsc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gprsc_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_last_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire gprsc_pkg::status_t st_i,
  output gprsc_pkg::cmd_t         cmd_o
);

  localparam logic [gprsc_pkg::AXIS_IDX_W-1:0] LastAxis = 2'(gprsc_pkg::NUM_AXES - 1);

  gprsc_pkg::state_e                   state_q, state_d;
  logic [gprsc_pkg::AXIS_IDX_W-1:0]    axis_q, axis_d;
  logic                                out_valid_q, out_valid_d;
  logic                                in_fire;
  logic                                emit_fire;

  assign in_ready_o  = (state_q == gprsc_pkg::S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign emit_fire   = (state_q == gprsc_pkg::S_EMIT) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  // Sequence one report: evaluate, optionally divide per axis, condition, emit; a rejected report skips to emit
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    unique case (state_q)
      gprsc_pkg::S_IDLE: begin
        if (in_fire && in_last_i) state_d = gprsc_pkg::S_EVAL;
      end
      gprsc_pkg::S_EVAL: begin
        axis_d = '0;
        if (!st_i.ok)             state_d = gprsc_pkg::S_EMIT;
        else if (st_i.calib_hit)  state_d = gprsc_pkg::S_DIV;
        else                      state_d = gprsc_pkg::S_COND;
      end
      gprsc_pkg::S_DIV: begin
        if (axis_q == LastAxis) begin
          state_d = gprsc_pkg::S_COND;
        end else begin
          axis_d  = axis_q + 2'd1;
        end
      end
      gprsc_pkg::S_COND: begin
        state_d = gprsc_pkg::S_EMIT;
      end
      gprsc_pkg::S_EMIT: begin
        if (emit_fire) state_d = gprsc_pkg::S_IDLE;
      end
      default: state_d = gprsc_pkg::S_IDLE;
    endcase
  end

  // Hold the result until the sink takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_fire)        out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gprsc_pkg::S_IDLE;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Drive datapath commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.in_accept = in_fire;
    cmd_o.eval      = (state_q == gprsc_pkg::S_EVAL);
    cmd_o.div       = (state_q == gprsc_pkg::S_DIV);
    cmd_o.calib_set = (state_q == gprsc_pkg::S_DIV) && (axis_q == LastAxis);
    cmd_o.cond      = (state_q == gprsc_pkg::S_COND);
    cmd_o.emit      = emit_fire;
    cmd_o.axis      = axis_q;
  end

  // A rejected report skips straight to the result
  a_reject_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gprsc_pkg::S_EVAL && !st_i.ok) |=> (state_q == gprsc_pkg::S_EMIT))
    else $error("rejected report did not go to emit");

  // Division walks the axes in order, one per cycle
  a_div_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gprsc_pkg::S_DIV && axis_q != LastAxis) |=>
      (state_q == gprsc_pkg::S_DIV && axis_q == $past(axis_q) + 2'd1))
    else $error("division did not advance to the next axis");

  // Result valid only rises after the emit state
  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == gprsc_pkg::S_EMIT))
    else $error("result valid rose outside emit");

endmodule

`default_nettype wire

@@ rtl/core/gprsc_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gprsc_dp #(
  parameter int unsigned CALIBRATION_SAMPLES = gprsc_pkg::CALIB_SAMPLES_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire gprsc_pkg::cmd_t                    cmd_i,
  output gprsc_pkg::status_t                      st_o,
  input  wire logic [gprsc_pkg::BYTE_W-1:0]       data_byte_i,
  input  wire logic [gprsc_pkg::KIND_W-1:0]       report_kind_i,
  input  wire logic                               last_byte_i,
  input  wire logic                               cfg_valid_i,
  input  wire logic [gprsc_pkg::DZ_W-1:0]         deadzone_i,
  output logic                                    parsed_ok_o,
  output logic [gprsc_pkg::KIND_W-1:0]            format_used_o,
  output logic [gprsc_pkg::BTN_W-1:0]             buttons_o,
  output logic [gprsc_pkg::AXIS_W-1:0]            left_x_o,
  output logic [gprsc_pkg::AXIS_W-1:0]            left_y_o,
  output logic [gprsc_pkg::AXIS_W-1:0]            right_x_o,
  output logic [gprsc_pkg::AXIS_W-1:0]            right_y_o,
  output logic [gprsc_pkg::COUNT_W-1:0]           update_count_o,
  output logic [gprsc_pkg::COUNT_W-1:0]           error_count_o
);

  localparam int unsigned AW   = gprsc_pkg::AXIS_W;
  localparam int unsigned NA   = gprsc_pkg::NUM_AXES;
  localparam int unsigned SUMW = $clog2(CALIBRATION_SAMPLES * 4095 + 1);
  localparam int unsigned SMPW = $clog2(CALIBRATION_SAMPLES + 1);
  localparam logic [SMPW-1:0] SampleEnd = SMPW'(CALIBRATION_SAMPLES);

  // Reciprocal of the sample count, exact for every sum of SUMW bits
  localparam int unsigned RSH = SUMW + $clog2(CALIBRATION_SAMPLES);
  localparam int unsigned RW  = SUMW + 1;
  localparam int unsigned PW  = SUMW + RW;
  localparam logic [RW-1:0] Recip =
    RW'(((64'd1 << RSH) + 64'(CALIBRATION_SAMPLES) - 64'd1) / 64'(CALIBRATION_SAMPLES));

  // Source bit in the full-format word for each canonical button
  localparam int unsigned SrcBit [gprsc_pkg::BTN_W] = '{
    2, 3, 0, 1, 6, 7, 9, 10, 16, 18, 19, 17, 22, 23, 8, 11, 12, 13, 24, 25, 14
  };

  function automatic logic [gprsc_pkg::BTN_W-1:0] map_full(input logic [31:0] w);
    logic [gprsc_pkg::BTN_W-1:0] b;
    b = '0;
    for (int i = 0; i < gprsc_pkg::BTN_W; i++) b[i] = w[SrcBit[i]];
    return b;
  endfunction

  function automatic logic [AW-1:0] stick_x(input logic [7:0] b0, input logic [7:0] b1);
    return {b1[3:0], b0};
  endfunction

  function automatic logic [AW-1:0] stick_y(input logic [7:0] b1, input logic [7:0] b2);
    return {b2, b1[7:4]};
  endfunction

  // Re-center, clamp and apply the deadzone
  function automatic logic [AW-1:0] cond_axis(input logic [AW-1:0] raw,
                                              input logic [AW-1:0] center,
                                              input logic [gprsc_pkg::DZ_W-1:0] dz);
    logic signed [AW+1:0] v;
    logic [AW-1:0]        c;
    logic [AW-1:0]        d;
    v = $signed({2'b00, raw}) - $signed({2'b00, center}) + $signed({2'b00, gprsc_pkg::AXIS_MID});
    if (v < 0)                                          c = '0;
    else if (v > $signed({2'b00, gprsc_pkg::AXIS_MAX})) c = gprsc_pkg::AXIS_MAX;
    else                                                c = v[AW-1:0];
    d = (c >= gprsc_pkg::AXIS_MID) ? (c - gprsc_pkg::AXIS_MID) : (gprsc_pkg::AXIS_MID - c);
    return (d <= {1'b0, dz}) ? gprsc_pkg::AXIS_MID : c;
  endfunction

  logic [gprsc_pkg::BYTE_W-1:0]   store_q [gprsc_pkg::STORE_BYTES];
  logic [gprsc_pkg::LEN_W-1:0]    cnt_q, cnt_inc, len_q;
  logic [gprsc_pkg::KIND_W-1:0]   kind_q;
  logic [gprsc_pkg::DZ_W-1:0]     dz_q;

  logic [gprsc_pkg::KIND_W-1:0]   fmt_sel;
  logic                           fi;
  logic                           ok;
  logic                           sample;
  logic [gprsc_pkg::BTN_W-1:0]    btn_sel;
  logic [AW-1:0]                  raw_sel [NA];

  logic                           ok_q;
  logic                           fi_q;
  logic [AW-1:0]                  raw_q [NA];
  logic                           done_q [2];
  logic [SMPW-1:0]                samples_q [2];
  logic [SUMW-1:0]                sums_q [2*NA];
  logic [AW-1:0]                  centers_q [2*NA];
  logic [gprsc_pkg::BTN_W-1:0]    held_btn_q;
  logic [AW-1:0]                  held_axes_q [NA];
  logic [gprsc_pkg::KIND_W-1:0]   held_fmt_q;
  logic [gprsc_pkg::COUNT_W-1:0]  acc_q, rej_q;

  logic [SUMW-1:0]                div_sum;
  logic [PW-1:0]                  div_prod;
  logic [AW-1:0]                  div_quo;

  // Capture report bytes; the count saturates at the store depth
  assign cnt_inc = cnt_q[gprsc_pkg::LEN_W-1] ? cnt_q : cnt_q + 5'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_accept && !cnt_q[gprsc_pkg::LEN_W-1]) begin
      store_q[cnt_q[gprsc_pkg::LEN_W-2:0]] <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      kind_q <= gprsc_pkg::KIND_UNKNOWN;
      len_q  <= '0;
    end else if (cmd_i.in_accept) begin
      if (cnt_q == '0) kind_q <= report_kind_i;
      if (last_byte_i) begin
        cnt_q <= '0;
        len_q <= cnt_inc;
      end else begin
        cnt_q <= cnt_inc;
      end
    end
  end

  // Take deadzone writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          dz_q <= gprsc_pkg::DZ_RESET;
    else if (cfg_valid_i) dz_q <= deadzone_i;
  end

  // Decode format, length check, buttons and raw sticks
  always_comb begin
    if (kind_q == gprsc_pkg::KIND_FULL || kind_q == gprsc_pkg::KIND_SHORT) begin
      fmt_sel = kind_q;
    end else begin
      fmt_sel = (len_q >= gprsc_pkg::FULL_MIN_LEN) ? gprsc_pkg::KIND_FULL
                                                   : gprsc_pkg::KIND_SHORT;
    end
    fi = (fmt_sel == gprsc_pkg::KIND_SHORT);
    ok = ((fmt_sel == gprsc_pkg::KIND_FULL)  && (len_q >= gprsc_pkg::FULL_MIN_LEN)) ||
         ((fmt_sel == gprsc_pkg::KIND_SHORT) && (len_q >= gprsc_pkg::SHORT_MIN_LEN));
    if (fi) begin
      btn_sel    = {store_q[4][4:0], store_q[3], store_q[2]};
      raw_sel[0] = stick_x(store_q[5], store_q[6]);
      raw_sel[1] = stick_y(store_q[6], store_q[7]);
      raw_sel[2] = stick_x(store_q[8], store_q[9]);
      raw_sel[3] = stick_y(store_q[9], store_q[10]);
    end else begin
      btn_sel    = map_full({store_q[7], store_q[6], store_q[5], store_q[4]});
      raw_sel[0] = stick_x(store_q[10], store_q[11]);
      raw_sel[1] = stick_y(store_q[11], store_q[12]);
      raw_sel[2] = stick_x(store_q[13], store_q[14]);
      raw_sel[3] = stick_y(store_q[14], store_q[15]);
    end
    sample = ok && !done_q[fi] && (btn_sel == '0);
  end

  assign st_o.ok        = ok;
  assign st_o.calib_hit = sample && (samples_q[fi] + SMPW'(1) == SampleEnd);

  // Latch the evaluation and update totals and calibration sums
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      ok_q <= ok;
      fi_q <= fi;
      for (int a = 0; a < NA; a++) raw_q[a] <= raw_sel[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_btn_q <= '0;
      held_fmt_q <= gprsc_pkg::FMT_NONE;
      acc_q      <= '0;
      rej_q      <= '0;
      for (int f = 0; f < 2; f++) begin
        done_q[f]    <= 1'b0;
        samples_q[f] <= '0;
      end
      for (int i = 0; i < 2*NA; i++) begin
        sums_q[i]    <= '0;
        centers_q[i] <= gprsc_pkg::AXIS_MID;
      end
      for (int a = 0; a < NA; a++) held_axes_q[a] <= gprsc_pkg::AXIS_MID;
    end else begin
      if (cmd_i.eval) begin
        if (ok) begin
          held_btn_q <= btn_sel;
          held_fmt_q <= fmt_sel;
          acc_q      <= acc_q + 32'd1;
        end else begin
          rej_q <= rej_q + 32'd1;
        end
        if (sample) begin
          samples_q[fi] <= samples_q[fi] + SMPW'(1);
          for (int a = 0; a < NA; a++) begin
            sums_q[{fi, 2'(a)}] <= sums_q[{fi, 2'(a)}] + SUMW'(raw_sel[a]);
          end
        end
      end
      if (cmd_i.div)       centers_q[{fi_q, cmd_i.axis}] <= div_quo;
      if (cmd_i.calib_set) done_q[fi_q] <= 1'b1;
      if (cmd_i.cond) begin
        for (int a = 0; a < NA; a++) begin
          held_axes_q[a] <= done_q[fi_q] ? cond_axis(raw_q[a], centers_q[{fi_q, 2'(a)}], dz_q)
                                         : gprsc_pkg::AXIS_MID;
        end
      end
    end
  end

  // Divide one axis sum by the sample count per cycle with a reciprocal multiply
  assign div_sum  = sums_q[{fi_q, cmd_i.axis}];
  assign div_prod = PW'(div_sum) * PW'(Recip);
  assign div_quo  = div_prod[RSH +: AW];

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      parsed_ok_o    <= ok_q;
      format_used_o  <= held_fmt_q;
      buttons_o      <= held_btn_q;
      left_x_o       <= held_axes_q[0];
      left_y_o       <= held_axes_q[1];
      right_x_o      <= held_axes_q[2];
      right_y_o      <= held_axes_q[3];
      update_count_o <= acc_q;
      error_count_o  <= rej_q;
    end
  end

  // A calibrated format has taken exactly the full sample count
  a_done_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!done_q[0] || samples_q[0] == SampleEnd) && (!done_q[1] || samples_q[1] == SampleEnd))
    else $error("calibrated format with wrong sample count");

  // Uncalibrated format leaves all axes at mid scale
  a_uncal_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cond && !done_q[fi_q]) |=>
      (held_axes_q[0] == gprsc_pkg::AXIS_MID && held_axes_q[1] == gprsc_pkg::AXIS_MID &&
       held_axes_q[2] == gprsc_pkg::AXIS_MID && held_axes_q[3] == gprsc_pkg::AXIS_MID))
    else $error("uncalibrated axes not at mid scale");

  // A rejected report leaves the held snapshot and the accepted total alone
  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.eval && !ok) |=> ($stable(held_btn_q) && $stable(held_fmt_q) && $stable(acc_q)))
    else $error("rejected report changed the snapshot");

endmodule

`default_nettype wire

@@ rtl/core/gamepad_report_stick_calibrator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel     Dir   Payload                                          Transfer
// in_byte_i   in    data_byte, report_kind, last_byte                valid && ready
// out_snap_o  out   parsed_ok, format_used, buttons, 4 axes, counts  valid && ready
// cfg_i       in    deadzone                                         valid && ready
//
// Non-final bytes transfer one per cycle while idle. After the final byte come evaluate,
// condition and emit (a rejected report skips condition); the report that completes a
// format's calibration also divides one axis per cycle, with one reciprocal multiplier.
// Reset clears counters, calibration and the held snapshot; deadzone returns to 48.
// A stalled result holds in the output register; non-final bytes still transfer
// meanwhile, and the next final byte waits in the emit state until it is taken.
module gamepad_report_stick_calibrator_core #(
  parameter int unsigned CALIBRATION_SAMPLES = gprsc_pkg::CALIB_SAMPLES_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gprsc_byte_if.sink   in_byte_i,
  gprsc_snap_if.source out_snap_o,
  gprsc_cfg_if.sink    cfg_i
);

  gprsc_pkg::cmd_t    cmd;
  gprsc_pkg::status_t st;

  assign cfg_i.ready = 1'b1;

  gprsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_byte_i.valid),
    .in_last_i   (in_byte_i.last_byte),
    .in_ready_o  (in_byte_i.ready),
    .out_valid_o (out_snap_o.valid),
    .out_ready_i (out_snap_o.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  gprsc_dp #(
    .CALIBRATION_SAMPLES (CALIBRATION_SAMPLES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .data_byte_i    (in_byte_i.data_byte),
    .report_kind_i  (in_byte_i.report_kind),
    .last_byte_i    (in_byte_i.last_byte),
    .cfg_valid_i    (cfg_i.valid),
    .deadzone_i     (cfg_i.deadzone),
    .parsed_ok_o    (out_snap_o.parsed_ok),
    .format_used_o  (out_snap_o.format_used),
    .buttons_o      (out_snap_o.buttons),
    .left_x_o       (out_snap_o.left_x),
    .left_y_o       (out_snap_o.left_y),
    .right_x_o      (out_snap_o.right_x),
    .right_y_o      (out_snap_o.right_y),
    .update_count_o (out_snap_o.update_count),
    .error_count_o  (out_snap_o.error_count)
  );

endmodule

`default_nettype wire
